>>> sv/lfap_pkg.sv
// shared types, constants and the color palette of the led frame animation player
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package lfap_pkg;

  // request type codes on the input channel
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FC_W    = 7;
  localparam int unsigned PPF_W   = 5;
  localparam int unsigned PIX_W   = 4;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ROW_W   = 12;  // frame index times row length plus slot
  localparam int unsigned CFG_W   = 7;   // widest register
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS      = 1'd1;

  localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 7'd0;
  localparam logic [PPF_W-1:0] PIXELS_RST      = 5'd24;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned HUE_COUNT = 14;
  // entry 13 first, entry 0 last
  localparam logic [HUE_COUNT-1:0][COLOR_W-1:0] HUE_TABLE = {
    24'hffffff, 24'hff0080, 24'hff00ff, 24'h8000ff, 24'h0000ff, 24'h0080ff,
    24'h00ffff, 24'h00ff40, 24'h00ff00, 24'h80ff00, 24'hffff00, 24'hff8000,
    24'hff0000, 24'h000000
  };

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [FC_W-1:0]  frame_count;
    logic [PPF_W-1:0] pixels_per_frame;
  } cfg_t;

  function automatic logic [COLOR_W-1:0] hue_color(input logic [WORD_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    c = '0;
    if (idx < WORD_W'(HUE_COUNT)) begin
      c = HUE_TABLE[idx[3:0]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/lfap_if.sv
// channel interfaces: request words in, pixel result words out
// depends on lfap_pkg for field widths
`default_nettype none

interface lfap_in_if;
  logic                             valid;
  logic                             ready;
  logic [lfap_pkg::REQ_W-1:0]       req_type;
  logic [lfap_pkg::ADDR_W-1:0]      word_addr;
  logic [lfap_pkg::WORD_W-1:0]      word_value;

  modport source(output valid, req_type, word_addr, word_value, input ready);
  modport sink(input valid, req_type, word_addr, word_value, output ready);
endinterface

interface lfap_out_if;
  logic                             valid;
  logic                             ready;
  logic                             shown;
  logic                             strip_select;
  logic [lfap_pkg::PIX_W-1:0]       pixel_index;
  logic [lfap_pkg::COLOR_W-1:0]     pixel_color;
  logic                             playing;
  logic                             last;

  modport source(output valid, shown, strip_select, pixel_index, pixel_color, playing, last,
                 input ready);
  modport sink(input valid, shown, strip_select, pixel_index, pixel_color, playing, last,
               output ready);
endinterface

`default_nettype wire

>>> sv/lfap_front.sv
// front end: accepts request words and turns them into queue commands
// depends on lfap_pkg and lfap_in_if
`default_nettype none

module lfap_front (
  lfap_in_if.sink           in_chan,
  input  wire logic         push_ready_i,
  output lfap_pkg::cmd_t    push_cmd_o,
  output logic              push_valid_o
);

  logic known;

  assign in_chan.ready = push_ready_i;

  always_comb begin
    known           = 1'b1;
    push_cmd_o.op   = lfap_pkg::OP_TICK;
    push_cmd_o.addr = in_chan.word_addr;
    push_cmd_o.value = in_chan.word_value;
    case (in_chan.req_type)
      lfap_pkg::REQ_TICK:  push_cmd_o.op = lfap_pkg::OP_TICK;
      lfap_pkg::REQ_WRITE: push_cmd_o.op = lfap_pkg::OP_WRITE;
      lfap_pkg::REQ_START: push_cmd_o.op = lfap_pkg::OP_START;
      default:             known = 1'b0;  // unknown types are taken and dropped
    endcase
  end

  assign push_valid_o = in_chan.valid && known;

endmodule

`default_nettype wire

>>> sv/lfap_queue.sv
// short command queue between front end and player back end
// depends on lfap_pkg for the command type and depth
`default_nettype none

module lfap_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  input  lfap_pkg::cmd_t      push_cmd_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output lfap_pkg::cmd_t      pop_cmd_o,
  input  wire logic           pop_ready_i
);

  localparam int unsigned PTR_W = $clog2(lfap_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(lfap_pkg::QUEUE_DEPTH + 1);

  lfap_pkg::cmd_t entry_q [lfap_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = count_q != CNT_W'(lfap_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(lfap_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(lfap_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/lfap_back.sv
// back end: frame store, playback state and the pixel read pipeline
// depends on lfap_pkg and lfap_out_if
`default_nettype none

module lfap_back #(
  parameter int unsigned MAX_FRAMES  = 64,
  parameter int unsigned MAX_PIXELS  = 24,
  parameter int unsigned STRIP_SPLIT = 12
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  lfap_pkg::cfg_t    cfg_i,
  input  wire logic         cmd_valid_i,
  input  lfap_pkg::cmd_t    cmd_i,
  output logic              cmd_ready_o,
  lfap_out_if.source        out_chan
);

  localparam int unsigned DEPTH  = MAX_FRAMES * (MAX_PIXELS + 1);
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = ((AW > lfap_pkg::ROW_W) ? AW : lfap_pkg::ROW_W) + 1;
  localparam int unsigned SLOT_W = $clog2(MAX_PIXELS);
  localparam int unsigned PPF_W  = lfap_pkg::PPF_W;
  localparam int unsigned FC_W   = lfap_pkg::FC_W;
  localparam int unsigned WORD_W = lfap_pkg::WORD_W;
  localparam int unsigned ROW_W  = lfap_pkg::ROW_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DUR   = 4'b0100,
    ST_PIX   = 4'b1000
  } state_e;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  state_e            state_q, state_d;
  logic [FC_W-1:0]   fi_q, fi_d;
  logic [WORD_W-1:0] ticks_q, ticks_d;
  logic              loaded_q, loaded_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              dur_oob_q, dur_oob_d;

  logic              p1_valid_q, p1_valid_d;
  logic [SLOT_W-1:0] p1_slot_q, p1_slot_d;
  logic              p1_black_q, p1_black_d;

  logic                             out_valid_q, out_valid_d;
  logic                             out_shown_q, out_shown_d;
  logic                             out_strip_q, out_strip_d;
  logic [lfap_pkg::PIX_W-1:0]       out_pix_q, out_pix_d;
  logic [lfap_pkg::COLOR_W-1:0]     out_color_q, out_color_d;
  logic                             out_playing_q, out_playing_d;
  logic                             out_last_q, out_last_d;

  logic              adv, take;
  logic [PPF_W-1:0]  npx, row_len;
  logic              running_now;
  logic [FC_W-1:0]   fi_adv;
  logic [ROW_W-1:0]  row_sel;
  logic [CW-1:0]     row_full, pix_full, wr_full;
  logic              row_ok, pix_ok, slot_used;
  logic [PPF_W-1:0]  p1_slot_ext;
  logic              rd_en, wr_en;
  logic [CW-1:0]     rd_addr;

  assign adv  = !out_valid_q || out_chan.ready;
  assign cmd_ready_o = (state_q == ST_IDLE) && !p1_valid_q && adv;
  assign take = cmd_valid_i && cmd_ready_o;

  assign npx     = (cfg_i.pixels_per_frame > PPF_W'(MAX_PIXELS)) ? PPF_W'(MAX_PIXELS)
                                                                  : cfg_i.pixels_per_frame;
  assign row_len = npx + PPF_W'(1);

  assign running_now = !((ticks_q == '0) && (fi_q >= cfg_i.frame_count));
  assign fi_adv = ((ticks_q == '0) && (fi_q < cfg_i.frame_count)) ? fi_q + FC_W'(1) : fi_q;
  assign row_sel = ROW_W'(fi_adv) * ROW_W'(row_len);

  assign row_full = CW'(row_sel);
  assign row_ok   = row_full < CW'(DEPTH);
  assign pix_full = CW'(row_q) + CW'(slot_q) + CW'(1);
  assign pix_ok   = pix_full < CW'(DEPTH);
  assign wr_full  = CW'(cmd_i.addr);
  assign slot_used = PPF_W'(slot_q) < npx;
  assign p1_slot_ext = PPF_W'(p1_slot_q);

  always_comb begin
    state_d   = state_q;
    fi_d      = fi_q;
    ticks_d   = ticks_q;
    loaded_d  = loaded_q;
    row_d     = row_q;
    slot_d    = slot_q;
    dur_oob_d = dur_oob_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;

    p1_valid_d = p1_valid_q;
    p1_slot_d  = p1_slot_q;
    p1_black_d = p1_black_q;

    out_valid_d   = out_valid_q;
    out_shown_d   = out_shown_q;
    out_strip_d   = out_strip_q;
    out_pix_d     = out_pix_q;
    out_color_d   = out_color_q;
    out_playing_d = out_playing_q;
    out_last_d    = out_last_q;

    if (out_valid_q && out_chan.ready) begin
      out_valid_d = 1'b0;
    end

    // drain the read stage into the output register
    if (adv) begin
      p1_valid_d = 1'b0;
      if (p1_valid_q) begin
        out_valid_d   = 1'b1;
        out_shown_d   = 1'b1;
        out_strip_d   = p1_slot_ext >= PPF_W'(STRIP_SPLIT);
        out_pix_d     = out_strip_d ? lfap_pkg::PIX_W'(p1_slot_ext - PPF_W'(STRIP_SPLIT))
                                    : lfap_pkg::PIX_W'(p1_slot_ext);
        out_color_d   = p1_black_q ? '0 : lfap_pkg::hue_color(rd_data_q);
        out_playing_d = running_now;
        out_last_d    = p1_slot_q == SLOT_W'(MAX_PIXELS - 1);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (cmd_i.op)
            lfap_pkg::OP_WRITE: begin
              wr_en = wr_full < CW'(DEPTH);
            end
            lfap_pkg::OP_START: begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_START;
            end
            lfap_pkg::OP_TICK: begin
              if (!loaded_q || ((ticks_q == '0) && (fi_adv >= cfg_i.frame_count))) begin
                // nothing loaded or animation finished: one blank word
                fi_d          = loaded_q ? fi_adv : fi_q;
                out_valid_d   = 1'b1;
                out_shown_d   = 1'b0;
                out_strip_d   = 1'b0;
                out_pix_d     = '0;
                out_color_d   = '0;
                out_playing_d = loaded_q ? 1'b0 : running_now;
                out_last_d    = 1'b1;
              end else if (ticks_q == '0) begin
                // duration ran out: step frame and fetch its duration word
                fi_d      = fi_adv;
                row_d     = row_sel;
                dur_oob_d = !row_ok;
                rd_en     = row_ok;
                rd_addr   = row_full;
                state_d   = ST_DUR;
              end else begin
                ticks_d = ticks_q - WORD_W'(1);
                row_d   = row_sel;
                slot_d  = '0;
                state_d = ST_PIX;
              end
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        ticks_d  = rd_data_q;
        fi_d     = '0;
        loaded_d = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_DUR: begin
        ticks_d = (dur_oob_q ? '0 : rd_data_q) - WORD_W'(1);
        slot_d  = '0;
        state_d = ST_PIX;
      end
      ST_PIX: begin
        if (adv) begin
          rd_en      = slot_used && pix_ok;
          rd_addr    = pix_full;
          p1_valid_d = 1'b1;
          p1_slot_d  = slot_q;
          p1_black_d = !(slot_used && pix_ok);
          slot_d     = slot_q + SLOT_W'(1);
          if (slot_q == SLOT_W'(MAX_PIXELS - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fi_q        <= '0;
      ticks_q     <= '0;
      loaded_q    <= 1'b0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fi_q        <= fi_d;
      ticks_q     <= ticks_d;
      loaded_q    <= loaded_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q         <= row_d;
    slot_q        <= slot_d;
    dur_oob_q     <= dur_oob_d;
    p1_slot_q     <= p1_slot_d;
    p1_black_q    <= p1_black_d;
    out_shown_q   <= out_shown_d;
    out_strip_q   <= out_strip_d;
    out_pix_q     <= out_pix_d;
    out_color_q   <= out_color_d;
    out_playing_q <= out_playing_d;
    out_last_q    <= out_last_d;
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_full[AW-1:0]] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr[AW-1:0]];
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.shown        = out_shown_q;
  assign out_chan.strip_select = out_strip_q;
  assign out_chan.pixel_index  = out_pix_q;
  assign out_chan.pixel_color  = out_color_q;
  assign out_chan.playing      = out_playing_q;
  assign out_chan.last         = out_last_q;

endmodule

`default_nettype wire

>>> sv/led_frame_animation_player.sv
// led frame animation player: front end, command queue, playback back end
// depends on lfap_pkg, lfap_if, lfap_front, lfap_queue and lfap_back
//
// usage
//   in_chan takes request words: tick, frame store write, or start/rewind.
//   out_chan gives pixel words; a tick yields MAX_PIXELS words (last on the
//   final one), or a single blank word with shown low when nothing is loaded
//   or the animation has ended. writes and starts give no words.
//   registers frame_count and pixels_per_frame are written through cfg_*_i;
//   the user must write them only while the block is idle; it does not enforce this.
// tick flow
//   a tick that steps to a new frame first fetches its duration word; a tick
//   that plays then walks the MAX_PIXELS pixel slots of its frame in order;
//   the single read port of the frame store reads one word per cycle while
//   out_chan does not stall, and a start reads the first duration word.
// reset
//   clears playback state, the queue and the output register; registers go
//   to frame_count 0, pixels_per_frame 24. the frame store is not cleared
//   and holds nothing meaningful until written.
// stalls
//   a stalled out_chan holds the pixel pipeline; the queue keeps taking
//   request words until it is full, then in_chan ready drops.
`default_nettype none

module led_frame_animation_player #(
  parameter int unsigned MAX_FRAMES  = 64,
  parameter int unsigned MAX_PIXELS  = 24,
  parameter int unsigned STRIP_SPLIT = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  lfap_in_if.sink                                 in_chan,
  lfap_out_if.source                              out_chan,
  input  wire logic                               cfg_we_i,
  input  wire logic [lfap_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lfap_pkg::CFG_W-1:0]         cfg_wdata_i
);

  lfap_pkg::cfg_t cfg_q, cfg_d;

  // queue handshake between the two halves
  lfap_pkg::cmd_t push_cmd, pop_cmd;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lfap_pkg::CFG_FRAME_COUNT: cfg_d.frame_count = cfg_wdata_i[lfap_pkg::FC_W-1:0];
        lfap_pkg::CFG_PIXELS:      cfg_d.pixels_per_frame = cfg_wdata_i[lfap_pkg::PPF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count      <= lfap_pkg::FRAME_COUNT_RST;
      cfg_q.pixels_per_frame <= lfap_pkg::PIXELS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify request words, drop unknown types
  lfap_front u_front (
    .in_chan      (in_chan),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd),
    .push_valid_o (push_valid)
  );

  lfap_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // frame store and playback
  lfap_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_PIXELS  (MAX_PIXELS),
    .STRIP_SPLIT (STRIP_SPLIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .out_chan    (out_chan)
  );

endmodule

`default_nettype wire

>>> tb/led_frame_animation_player_tb.sv
// testbench for the led frame animation player: predicts every pixel word of every tick
// and checks it against the block under random valid and ready pressure
// depends on lfap_pkg, lfap_if and led_frame_animation_player

typedef struct packed {
  logic        shown;
  logic        strip;
  logic [3:0]  pix;
  logic [23:0] color;
  logic        playing;
  logic        last;
} pixel_word_t;

class pixel_scoreboard #(int FRAMES = 64, int PIXELS = 24, int SPLIT = 12);
  logic [15:0] frame_words [FRAMES*(PIXELS+1)];
  logic [6:0]  frame_at;
  logic [15:0] dwell;
  bit          armed;
  logic [6:0]  n_frames;
  logic [4:0]  n_pixels;
  pixel_word_t due_pixels[$];
  int          mismatches;
  int          requests;
  int          words_checked;
  int          shown_words;

  function new();
    foreach (frame_words[a]) frame_words[a] = '0;
    frame_at      = '0;
    dwell         = '0;
    armed         = 1'b0;
    n_frames      = lfap_pkg::FRAME_COUNT_RST;
    n_pixels      = lfap_pkg::PIXELS_RST;
    mismatches    = 0;
    requests      = 0;
    words_checked = 0;
    shown_words   = 0;
  endfunction

  function void set_register(logic [lfap_pkg::CFG_IDX_W-1:0] idx,
                             logic [lfap_pkg::CFG_W-1:0] data);
    case (idx)
      lfap_pkg::CFG_FRAME_COUNT: n_frames = data[6:0];
      lfap_pkg::CFG_PIXELS:      n_pixels = data[4:0];
      default: ;
    endcase
  endfunction

  // addresses past the store read as zero
  function logic [15:0] word_at(int addr);
    return (addr < FRAMES * (PIXELS + 1)) ? frame_words[addr] : 16'd0;
  endfunction

  function logic [23:0] hue(logic [15:0] idx);
    case (idx)
      16'd1:   return 24'hff0000;
      16'd2:   return 24'hff8000;
      16'd3:   return 24'hffff00;
      16'd4:   return 24'h80ff00;
      16'd5:   return 24'h00ff00;
      16'd6:   return 24'h00ff40;
      16'd7:   return 24'h00ffff;
      16'd8:   return 24'h0080ff;
      16'd9:   return 24'h0000ff;
      16'd10:  return 24'h8000ff;
      16'd11:  return 24'hff00ff;
      16'd12:  return 24'hff0080;
      16'd13:  return 24'hffffff;
      default: return 24'h000000;
    endcase
  endfunction

  function void emit(bit shown, bit strip, int pix, logic [23:0] color, bit last);
    pixel_word_t w;
    w.shown   = shown;
    w.strip   = strip;
    w.pix     = 4'(pix);
    w.color   = color;
    w.playing = !(dwell == 16'd0 && frame_at >= n_frames);
    w.last    = last;
    due_pixels.push_back(w);
  endfunction

  function void note_request(logic [1:0] req, logic [10:0] addr, logic [15:0] value);
    int npx;
    int row;
    bit finished;
    requests++;
    case (req)
      lfap_pkg::REQ_WRITE: begin
        if (addr < FRAMES * (PIXELS + 1)) frame_words[addr] = value;
      end
      lfap_pkg::REQ_START: begin
        frame_at = '0;
        dwell    = word_at(0);
        armed    = 1'b1;
      end
      lfap_pkg::REQ_TICK: begin
        npx      = (n_pixels > PIXELS) ? PIXELS : n_pixels;
        finished = 1'b0;
        if (armed && dwell == 16'd0) begin
          if (frame_at < n_frames) frame_at++;
          if (frame_at >= n_frames) finished = 1'b1;
          else dwell = word_at(int'(frame_at) * (npx + 1));
        end
        if (!armed || finished) begin
          emit(1'b0, 1'b0, 0, 24'h0, 1'b1);
        end else begin
          dwell = dwell - 16'd1;
          row   = int'(frame_at) * (npx + 1);
          for (int s = 0; s < PIXELS; s++) begin
            emit(1'b1, s >= SPLIT, (s >= SPLIT) ? s - SPLIT : s,
                 (s < npx) ? hue(word_at(row + 1 + s)) : 24'h0, s == PIXELS - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function string describe(pixel_word_t w);
    return $sformatf("shown=%0b strip=%0b index=%0d color=%06h playing=%0b last=%0b",
                     w.shown, w.strip, w.pix, w.color, w.playing, w.last);
  endfunction

  function void check_word(pixel_word_t got);
    pixel_word_t want;
    words_checked++;
    if (got.shown === 1'b1) shown_words++;
    if (due_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("pixel word with none due: %s", describe(got));
    end else begin
      want = due_pixels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("pixel word mismatch\n  expected %s\n  actual   %s",
                   describe(want), describe(got));
        end
      end
    end
  endfunction
endclass

module led_frame_animation_player_tb;
  import lfap_pkg::*;

  localparam int MAX_FRAMES  = 64;
  localparam int MAX_PIXELS  = 24;
  localparam int STRIP_SPLIT = 12;
  localparam int STORE_WORDS = MAX_FRAMES * (MAX_PIXELS + 1);
  // longest honest silence is the settle pause plus an input gap, an output stall
  // and the pipeline fill; this is far above that
  localparam int QUIET_LIMIT = 2000;
  // type code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int in_gap_odds;     // 0 means no gaps, else one gap in this many words
  int out_stall_odds;  // same for stalls on the result side
  int hold_left;
  int quiet_cycles;

  lfap_in_if  in_ch();
  lfap_out_if out_ch();

  pixel_scoreboard #(MAX_FRAMES, MAX_PIXELS, STRIP_SPLIT) scoreboard;

  led_frame_animation_player #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_PIXELS (MAX_PIXELS),
    .STRIP_SPLIT(STRIP_SPLIT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_ch),
    .out_chan   (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // everything is sampled on the rising edge; the scoreboard sees register
  // writes, accepted request words and accepted pixel words in that order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) scoreboard.set_register(cfg_idx, cfg_wdata);
      if (in_ch.valid && in_ch.ready) begin
        scoreboard.note_request(in_ch.req_type, in_ch.word_addr, in_ch.word_value);
      end
      if (out_ch.valid && out_ch.ready) begin
        scoreboard.check_word({out_ch.shown, out_ch.strip_select, out_ch.pixel_index,
                               out_ch.pixel_color, out_ch.playing, out_ch.last});
      end
      quiet_cycles <= ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                       cfg_we) ? 0 : quiet_cycles + 1;
    end
  end

  // result side: ready drops in bursts of random length
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
      out_ch.ready <= 1'b0;
      hold_left    <= $urandom_range(0, 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the word is taken;
  // valid stays high into the next call unless that call opens a gap
  task automatic send_request(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
                              logic [WORD_W-1:0] value);
    if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.word_addr  <= addr;
    in_ch.word_value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic write_word(int addr, logic [WORD_W-1:0] value);
    send_request(REQ_WRITE, ADDR_W'(addr), value);
  endtask

  // address and value of ticks and starts are don't-care, so they carry noise
  task automatic tick();
    send_request(REQ_TICK, ADDR_W'($urandom), WORD_W'($urandom));
  endtask

  task automatic rewind();
    send_request(REQ_START, ADDR_W'($urandom), WORD_W'($urandom));
  endtask

  // both registers in one burst so the write enable rises only once
  task automatic program_settings(int fc, int ppf);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FRAME_COUNT;
    cfg_wdata <= CFG_W'(fc);
    @(negedge clk_i);
    cfg_idx   <= CFG_PIXELS;
    cfg_wdata <= CFG_W'(ppf);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // drain all due pixel words, then give a trailing write or start time to retire
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (scoreboard.due_pixels.size() != 0) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // palette index, mostly in range, sometimes any 16 bit value
  function automatic logic [WORD_W-1:0] pick_hue();
    return ($urandom_range(0, 7) == 0) ? WORD_W'($urandom) : WORD_W'($urandom_range(0, 15));
  endfunction

  initial begin
    int fc;
    int ppf;
    int npx;
    int rows;
    int span;
    int burst;
    int pick;
    int random_items;
    int phases;
    logic [ADDR_W-1:0] addr;

    scoreboard       = new();
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_TICK;
    in_ch.word_addr  = '0;
    in_ch.word_value = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_FRAME_COUNT;
    cfg_wdata        = '0;
    in_gap_odds      = 0;
    out_stall_odds   = 0;
    random_items     = 0;
    phases           = 0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // nothing loaded: one blank word, then an ignored type and writes past the store
    tick();
    send_request(REQ_UNUSED, 11'h7ff, 16'hffff);
    send_request(REQ_WRITE, 11'h7ff, 16'h5a5a);
    write_word(STORE_WORDS, 16'h00ff);
    settle();
    // still not loaded, but now the frame count makes it report playing
    program_settings(3, 24);
    tick();
    settle();

    // fill the whole store so no later read can hit an unwritten entry
    in_gap_odds    = 6;
    out_stall_odds = 6;
    for (int a = 0; a < STORE_WORDS; a++) write_word(a, pick_hue());
    settle();

    // frame 0 walks the palette and the out of range indices,
    // frame 1 has a zero duration and wraps the counter
    program_settings(2, 24);
    write_word(0, 16'd2);
    for (int s = 0; s < MAX_PIXELS; s++) begin
      write_word(1 + s, (s < 16) ? WORD_W'(s) : (16'hfff0 | WORD_W'(s)));
    end
    write_word(MAX_PIXELS + 1, 16'd0);
    for (int s = 0; s < MAX_PIXELS; s++) write_word(MAX_PIXELS + 2 + s, WORD_W'(13 - s % 14));
    rewind();
    repeat (4) tick();
    rewind();
    tick();
    settle();

    // rows of a duration word only, run past the last frame and stay there
    program_settings(3, 0);
    write_word(0, 16'd1);
    write_word(1, 16'd1);
    write_word(2, 16'd1);
    rewind();
    repeat (5) tick();
    settle();
    // frame index now sits above the shrunk frame count and must not move
    program_settings(1, 0);
    tick();
    settle();

    // pixel count above the maximum is capped; a zero first duration is skipped
    program_settings(1, 31);
    write_word(0, 16'd0);
    rewind();
    tick();
    write_word(0, 16'd1);
    rewind();
    repeat (2) tick();
    settle();

    // largest frame count: walk every stored frame and on past the end of the store
    program_settings(127, 24);
    for (int f = 0; f < MAX_FRAMES; f++) write_word(f * (MAX_PIXELS + 1), 16'd1);
    rewind();
    repeat (MAX_FRAMES + 3) tick();
    settle();

    // random phases: new settings, fresh rows for the first frames, then mostly ticks
    // with starts, store writes and junk mixed in; the last phases run without idling
    while (random_items < 360) begin
      case ($urandom_range(0, 9))
        0:       fc = 0;
        1:       fc = 1;
        2:       fc = 127;
        3:       fc = MAX_FRAMES;
        default: fc = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       ppf = 0;
        1:       ppf = 1;
        2:       ppf = MAX_PIXELS;
        3:       ppf = 31;
        4:       ppf = STRIP_SPLIT;
        5:       ppf = STRIP_SPLIT + 1;
        default: ppf = $urandom_range(1, MAX_PIXELS);
      endcase
      program_settings(fc, ppf);
      if (random_items >= 300) begin
        in_gap_odds    = 0;
        out_stall_odds = 0;
      end else begin
        in_gap_odds    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        out_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      end

      npx  = (ppf > MAX_PIXELS) ? MAX_PIXELS : ppf;
      rows = (fc < 6) ? fc : 6;
      span = rows * (npx + 1);
      for (int f = 0; f < rows; f++) begin
        // short durations so frames advance; zero and the maximum now and then
        case ($urandom_range(0, 31))
          0:       write_word(f * (npx + 1), 16'd0);
          1:       write_word(f * (npx + 1), 16'hffff);
          default: write_word(f * (npx + 1), WORD_W'($urandom_range(1, 3)));
        endcase
        for (int s = 0; s < npx; s++) write_word(f * (npx + 1) + 1 + s, pick_hue());
      end
      if ($urandom_range(0, 4) != 0) rewind();

      burst = $urandom_range(15, 35);
      for (int i = 0; i < burst; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
          tick();
          random_items++;
        end else if (pick < 80) begin
          addr = ($urandom_range(0, 3) == 0 || span == 0) ? ADDR_W'($urandom)
                                                          : ADDR_W'($urandom_range(0, span - 1));
          write_word(addr, pick_hue());
          if (addr < STORE_WORDS) random_items++;
        end else if (pick < 92) begin
          rewind();
          random_items++;
        end else begin
          send_request(REQ_UNUSED, ADDR_W'($urandom), WORD_W'($urandom));
        end
      end
      settle();
      phases++;
    end

    $display("ran %0d request words over the directed cases and %0d random setting phases",
             scoreboard.requests, phases);
    $display("checked %0d pixel words (%0d shown), %0d mismatches",
             scoreboard.words_checked, scoreboard.shown_words, scoreboard.mismatches);
    if (scoreboard.mismatches == 0 && scoreboard.due_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lfap_pkg.sv
sv/lfap_if.sv
sv/lfap_front.sv
sv/lfap_queue.sv
sv/lfap_back.sv
sv/led_frame_animation_player.sv
tb/led_frame_animation_player_tb.sv
